### hdl/pcpm_pkg.sv
`timescale 1ns / 1ps

package pcpm_pkg;

  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned ITEM_W     = 3;
  localparam int unsigned NUM_BTN    = 3;
  localparam int unsigned NUM_VALUES = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 8'd255;
  localparam logic [ITEM_W-1:0]  LAST_ITEM = 3'd3;
  // items 0..3 map onto a stored value; anything above edits nothing
  localparam logic [ITEM_W-1:0]  TOP_VALUE_ITEM = 3'd3;

  localparam logic [COUNT_W-1:0] LONG_RESET  = 16'd1000;
  localparam logic [COUNT_W-1:0] SHORT_RESET = 16'd50;

  localparam int unsigned BTN_SELECT = 0;
  localparam int unsigned BTN_PLUS   = 1;
  localparam int unsigned BTN_MINUS  = 2;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // register indexes on the configuration port
  localparam logic REG_LONG  = 1'b0;
  localparam logic REG_SHORT = 1'b1;

  typedef enum logic [1:0] {
    CODE_NONE  = 2'd0,
    CODE_SHORT = 2'd1,
    CODE_LONG  = 2'd2
  } code_t;

  typedef logic [VALUE_W-1:0] value_t;

  // press codes saved at the previous poll
  typedef struct packed {
    code_t sel;
    code_t plus;
    code_t minus;
  } codes_t;

  // one step handed from the input register to the update logic
  typedef struct packed {
    logic                 fire;
    logic                 command;
    logic [NUM_BTN-1:0]   level;
  } step_t;

  // menu state as the result register sees it
  typedef struct packed {
    logic                          driver;
    logic [ITEM_W-1:0]             item;
    logic [NUM_VALUES-1:0][VALUE_W-1:0] values;
  } view_t;

endpackage

### hdl/pcpm_if.sv
`timescale 1ns / 1ps

interface pcpm_in_if;
  logic valid;
  logic ready;
  logic command;
  logic select_level;
  logic plus_level;
  logic minus_level;

  modport source (output valid, command, select_level, plus_level, minus_level, input ready);
  modport sink (input valid, command, select_level, plus_level, minus_level, output ready);
endinterface

interface pcpm_out_if;
  logic       valid;
  logic       ready;
  logic       driver_selected;
  logic [2:0] item_index;
  logic [7:0] first_kd;
  logic [7:0] first_ki;
  logic [7:0] first_kp;
  logic [7:0] first_factor;
  logic [7:0] second_kd;
  logic [7:0] second_ki;
  logic [7:0] second_kp;
  logic [7:0] second_factor;

  modport source (
    output valid, driver_selected, item_index,
           first_kd, first_ki, first_kp, first_factor,
           second_kd, second_ki, second_kp, second_factor,
    input  ready
  );
  modport sink (
    input  valid, driver_selected, item_index,
           first_kd, first_ki, first_kp, first_factor,
           second_kd, second_ki, second_kp, second_factor,
    output ready
  );
endinterface

### hdl/pcpm_buttons.sv
`timescale 1ns / 1ps

module pcpm_buttons
  import pcpm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  step_t              step,
  input  logic [COUNT_W-1:0] long_ticks,
  input  logic [COUNT_W-1:0] short_ticks,
  output codes_t             codes
);

  logic [NUM_BTN-1:0][COUNT_W-1:0] counts;
  logic [NUM_BTN-1:0][COUNT_W-1:0] counts_next;
  code_t [NUM_BTN-1:0]             code_arr;
  code_t [NUM_BTN-1:0]             code_arr_next;
  logic                            tick_done;

  always_comb begin
    counts_next   = counts;
    code_arr_next = code_arr;
    tick_done     = 1'b0;
    if (step.command == CMD_TICK) begin
      // only the highest-priority held button counts
      for (int b = 0; b < NUM_BTN; b++) begin
        if (!tick_done && !step.level[b]) begin
          tick_done = 1'b1;
          if (counts[b] != COUNT_MAX) begin
            counts_next[b] = counts[b] + 16'd1;
          end
        end
      end
    end else begin
      for (int b = 0; b < NUM_BTN; b++) begin
        code_arr_next[b] = CODE_NONE;
        if (step.level[b]) begin
          if (counts[b] >= long_ticks) begin
            code_arr_next[b] = CODE_LONG;
          end else if (counts[b] >= short_ticks) begin
            code_arr_next[b] = CODE_SHORT;
          end
          counts_next[b] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts   <= '0;
      code_arr <= {NUM_BTN{CODE_NONE}};
    end else if (step.fire) begin
      counts   <= counts_next;
      code_arr <= code_arr_next;
    end
  end

  assign codes.sel   = code_arr[BTN_SELECT];
  assign codes.plus  = code_arr[BTN_PLUS];
  assign codes.minus = code_arr[BTN_MINUS];

endmodule

### hdl/pcpm_menu.sv
`timescale 1ns / 1ps

module pcpm_menu
  import pcpm_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  step_t  step,
  input  codes_t codes,
  output view_t  view_next
);

  logic                               driver;
  logic [ITEM_W-1:0]                  item;
  logic [NUM_VALUES-1:0][VALUE_W-1:0] values;

  logic                       driver_p;
  logic [ITEM_W-1:0]          item_p;
  logic [$clog2(NUM_VALUES)-1:0] idx;
  value_t                     cur;
  value_t                     up;
  value_t                     down;
  logic [NUM_VALUES-1:0][VALUE_W-1:0] values_p;

  always_comb begin
    driver_p = driver;
    item_p   = item;
    case (codes.sel)
      CODE_LONG: begin
        driver_p = ~driver;
        item_p   = '0;
      end
      CODE_SHORT: begin
        if (item < LAST_ITEM) begin
          item_p = item + 3'd1;
        end else if (item == LAST_ITEM) begin
          item_p = '0;
        end
      end
      default: begin
      end
    endcase

    // edits still go to the driver selected when the poll began
    idx  = {driver, item_p[1:0]};
    cur  = values[idx];
    up   = (codes.plus == CODE_SHORT && cur != VALUE_MAX) ? cur + 8'd1 : cur;
    down = (codes.minus == CODE_SHORT && up != '0) ? up - 8'd1 : up;

    values_p = values;
    if (item_p <= TOP_VALUE_ITEM) begin
      values_p[idx] = down;
    end

    if (step.command == CMD_POLL) begin
      view_next.driver = driver_p;
      view_next.item   = item_p;
      view_next.values = values_p;
    end else begin
      view_next.driver = driver;
      view_next.item   = item;
      view_next.values = values;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      driver <= 1'b0;
      item   <= '0;
      values <= '0;
    end else if (step.fire) begin
      driver <= view_next.driver;
      item   <= view_next.item;
      values <= view_next.values;
    end
  end

endmodule

### hdl/press_classified_param_menu_top.sv
`timescale 1ns / 1ps

// channel  | dir | payload                                      | accepted when
// ---------+-----+----------------------------------------------+------------------
// cmd      | in  | command, select/plus/minus levels            | valid && ready
// res      | out | driver_selected, item_index, 8 tuning values | valid && ready
// APB      | in  | long_press_ticks @0x0, short_press_ticks @0x4 | psel&penable&pwrite
//
// One request per clock while the result is not stalled. A request is latched
// in the input register; when it advances, the counter/menu update runs and
// the result register loads the new menu state.
// Synchronous active-high reset clears counters, codes, menu and values and
// loads the default thresholds. A stalled result holds the pipe; the input
// register still accepts while the result register is free to drain.

module press_classified_param_menu_top
  import pcpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pcpm_in_if.sink     cmd,
  pcpm_out_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [COUNT_W-1:0] long_ticks;
  logic [COUNT_W-1:0] short_ticks;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_ticks  <= LONG_RESET;
      short_ticks <= SHORT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LONG:  long_ticks  <= pwdata[COUNT_W-1:0];
        REG_SHORT: short_ticks <= pwdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LONG:  prdata = {16'd0, long_ticks};
      REG_SHORT: prdata = {16'd0, short_ticks};
      default:   prdata = '0;
    endcase
  end

  // input register
  logic               in_valid;
  logic               in_command;
  logic [NUM_BTN-1:0] in_level;
  logic               advance;
  step_t              step;

  // result register
  logic  out_valid;
  view_t out_view;
  view_t view_next;

  codes_t codes;

  assign advance   = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_command          <= cmd.command;
      in_level[BTN_SELECT] <= cmd.select_level;
      in_level[BTN_PLUS]   <= cmd.plus_level;
      in_level[BTN_MINUS]  <= cmd.minus_level;
    end
  end

  assign step.fire    = advance;
  assign step.command = in_command;
  assign step.level   = in_level;

  pcpm_buttons u_buttons (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .long_ticks  (long_ticks),
    .short_ticks (short_ticks),
    .codes       (codes)
  );

  // menu uses the codes saved by the previous poll, before they are replaced
  pcpm_menu u_menu (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .codes     (codes),
    .view_next (view_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_view <= view_next;
    end
  end

  assign res.valid           = out_valid;
  assign res.driver_selected = out_view.driver;
  assign res.item_index      = out_view.item;
  assign res.first_kd        = out_view.values[0];
  assign res.first_ki        = out_view.values[1];
  assign res.first_kp        = out_view.values[2];
  assign res.first_factor    = out_view.values[3];
  assign res.second_kd       = out_view.values[4];
  assign res.second_ki       = out_view.values[5];
  assign res.second_kp       = out_view.values[6];
  assign res.second_factor   = out_view.values[7];

endmodule
